// ===== rtl/nsfp_pkg.sv =====
// shared types, constants and tables of the nmea sentence field parser
`timescale 1ns / 1ps
`default_nettype none
package nsfp_pkg;

    // default parameter values
    localparam int FIELD_MAX_CHARS_DEF = 16;
    localparam int FRACTION_DIGITS_DEF = 5;

    // field widths
    localparam int VALUE_W = 40;
    localparam int CFG_W   = 38;
    localparam int TIMEDATE_CHARS = 6;
    localparam logic [VALUE_W-1:0] MAG_MAX = 40'd549755813887;

    // characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_E      = 8'h45;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_W      = 8'h57;

    // configuration register indexes
    localparam logic [2:0] CFG_LAT_MAX  = 3'd0;
    localparam logic [2:0] CFG_LON_MAX  = 3'd1;
    localparam logic [2:0] CFG_ALT_MIN  = 3'd2;
    localparam logic [2:0] CFG_ALT_MAX  = 3'd3;
    localparam logic [2:0] CFG_DOP_MAX  = 3'd4;
    localparam logic [2:0] CFG_SPD_MAX  = 3'd5;
    localparam logic [2:0] CFG_SATS_MAX = 3'd6;
    localparam logic [2:0] CFG_FIX_MAX  = 3'd7;

    // quantity codes
    localparam logic [3:0] Q_TIME    = 4'd0;
    localparam logic [3:0] Q_DATE    = 4'd1;
    localparam logic [3:0] Q_LAT     = 4'd2;
    localparam logic [3:0] Q_LON     = 4'd3;
    localparam logic [3:0] Q_LATDIR  = 4'd4;
    localparam logic [3:0] Q_LONDIR  = 4'd5;
    localparam logic [3:0] Q_ALT     = 4'd6;
    localparam logic [3:0] Q_FIX     = 4'd7;
    localparam logic [3:0] Q_SATS    = 4'd8;
    localparam logic [3:0] Q_HDOP    = 4'd9;
    localparam logic [3:0] Q_VDOP    = 4'd10;
    localparam logic [3:0] Q_SPEED   = 4'd11;
    localparam logic [3:0] Q_MODE1   = 4'd12;
    localparam logic [3:0] Q_MODE2   = 4'd13;
    localparam logic [3:0] Q_MODEIND = 4'd14;
    localparam logic [3:0] Q_NONE    = 4'd15;

    // sentence kinds
    localparam logic [2:0] K_RMC = 3'd0;
    localparam logic [2:0] K_VTG = 3'd1;
    localparam logic [2:0] K_GGA = 3'd2;
    localparam logic [2:0] K_GSA = 3'd3;
    localparam logic [2:0] K_GSV = 3'd4;
    localparam logic [2:0] K_GLL = 3'd5;

    // configuration registers
    typedef struct packed {
        logic [33:0] lat_max;
        logic [34:0] lon_max;
        logic [37:0] alt_min;
        logic [37:0] alt_max;
        logic [33:0] dop_max;
        logic [24:0] spd_max;
        logic [6:0]  sats_max;
        logic [3:0]  fix_max;
    } t_cfg;

    // one result item
    typedef struct packed {
        logic [3:0]         quantity;
        logic [VALUE_W-1:0] value;
        logic [2:0]         kind;
    } t_item;

    // results of one byte
    typedef struct packed {
        logic [1:0] cnt;
        t_item      item0;
        t_item      item1;
    } t_res;

    // power of ten for elaboration-time constants
    function automatic logic [63:0] pow10(input int n);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < n; i++) p = p * 64'd10;
        return p;
    endfunction

    // header letters of each sentence type
    function automatic logic [7:0] hdr_char(input logic [2:0] t, input logic [2:0] pos);
        logic [39:0] s;
        unique case (t)
            K_RMC:   s = "GPRMC";
            K_VTG:   s = "GPVTG";
            K_GGA:   s = "GPGGA";
            K_GSA:   s = "GPGSA";
            K_GSV:   s = "GPGSV";
            default: s = "GPGLL";
        endcase
        unique case (pos)
            3'd0:    hdr_char = s[39:32];
            3'd1:    hdr_char = s[31:24];
            3'd2:    hdr_char = s[23:16];
            3'd3:    hdr_char = s[15:8];
            default: hdr_char = s[7:0];
        endcase
    endfunction

    // number of fields of each sentence type
    function automatic logic [4:0] field_count(input logic [2:0] t);
        unique case (t)
            K_RMC:   field_count = 5'd13;
            K_VTG:   field_count = 5'd10;
            K_GGA:   field_count = 5'd15;
            K_GSA:   field_count = 5'd18;
            K_GSV:   field_count = 5'd20;
            default: field_count = 5'd8;
        endcase
    endfunction

    // quantity carried by a field of a sentence type
    function automatic logic [3:0] qty_map(input logic [2:0] t, input logic [4:0] f);
        qty_map = Q_NONE;
        unique case (t)
            K_RMC: begin
                unique case (f)
                    5'd0:    qty_map = Q_TIME;
                    5'd2:    qty_map = Q_LAT;
                    5'd3:    qty_map = Q_LATDIR;
                    5'd4:    qty_map = Q_LON;
                    5'd5:    qty_map = Q_LONDIR;
                    5'd8:    qty_map = Q_DATE;
                    5'd11:   qty_map = Q_MODEIND;
                    default: qty_map = Q_NONE;
                endcase
            end
            K_VTG: begin
                unique case (f)
                    5'd6:    qty_map = Q_SPEED;
                    5'd8:    qty_map = Q_MODEIND;
                    default: qty_map = Q_NONE;
                endcase
            end
            K_GGA: begin
                unique case (f)
                    5'd0:    qty_map = Q_TIME;
                    5'd1:    qty_map = Q_LAT;
                    5'd2:    qty_map = Q_LATDIR;
                    5'd3:    qty_map = Q_LON;
                    5'd4:    qty_map = Q_LONDIR;
                    5'd5:    qty_map = Q_FIX;
                    5'd6:    qty_map = Q_SATS;
                    5'd7:    qty_map = Q_HDOP;
                    5'd8:    qty_map = Q_ALT;
                    default: qty_map = Q_NONE;
                endcase
            end
            K_GSA: begin
                unique case (f)
                    5'd0:    qty_map = Q_MODE1;
                    5'd1:    qty_map = Q_MODE2;
                    5'd15:   qty_map = Q_HDOP;
                    5'd16:   qty_map = Q_VDOP;
                    default: qty_map = Q_NONE;
                endcase
            end
            K_GLL: begin
                unique case (f)
                    5'd0:    qty_map = Q_LAT;
                    5'd1:    qty_map = Q_LATDIR;
                    5'd2:    qty_map = Q_LON;
                    5'd3:    qty_map = Q_LONDIR;
                    5'd4:    qty_map = Q_TIME;
                    5'd6:    qty_map = Q_MODEIND;
                    default: qty_map = Q_NONE;
                endcase
            end
            default: qty_map = Q_NONE;
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== rtl/nmea_sentence_field_parser_top.sv =====
// top level of the nmea sentence field parser: ports, registers, input stage, result queue
//
// channel   direction  handshake                    payload
// s_axis    in         i_s_axis_tvalid/o_s_axis_tready  tdata: rx_byte
// m_axis    out        o_m_axis_tvalid/i_m_axis_tready  tdata: value; tuser: quantity, kind
// cfg       in         i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
// one byte per cycle: a byte is parsed from the input register in the cycle after its
// transfer, and its results (up to two) land in an eight-entry result queue at the next edge
// results are offered once they are written into the result queue, and transfer out
// while i_m_axis_tready is high
// synchronous active-low reset returns to hunting and loads register defaults
// s_axis stalls when the result queue has fewer than four free entries
`timescale 1ns / 1ps
`default_nettype none
module nmea_sentence_field_parser_top import nsfp_pkg::*; #(
    parameter int FIELD_MAX_CHARS = FIELD_MAX_CHARS_DEF,
    parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  wire logic [7:0]         i_s_axis_tdata,   // [7:0] rx_byte
    output logic                    o_m_axis_tvalid,
    input  wire logic               i_m_axis_tready,
    output logic [VALUE_W-1:0]      o_m_axis_tdata,   // [39:0] value
    output logic [6:0]              o_m_axis_tuser,   // [3:0] quantity, [6:4] sentence_kind
    output logic                    o_m_axis_tlast,   // last_item
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [CFG_W-1:0]   i_cfg_data
);

    localparam int DEPTH = 8;
    localparam int PW = $clog2(DEPTH);

    t_cfg           r_cfg;
    logic           r_in_valid;
    logic [7:0]     r_in_byte;
    t_res           res;
    t_item          r_mem [DEPTH];
    logic           r_last [DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [PW:0]    r_count;
    logic           in_xfer, out_xfer;

    assign o_cfg_ready = 1'b1;
    assign o_s_axis_tready = (r_count <= (PW+1)'(DEPTH - 4));
    assign in_xfer = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = (r_count != '0);
    assign out_xfer = o_m_axis_tvalid && i_m_axis_tready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lat_max  <= 34'd900000000;
            r_cfg.lon_max  <= 35'd1800000000;
            r_cfg.alt_min  <= 38'(-64'sd50000000);
            r_cfg.alt_max  <= 38'd1000000000;
            r_cfg.dop_max  <= 34'd9999000;
            r_cfg.spd_max  <= 25'd25500000;
            r_cfg.sats_max <= 7'd12;
            r_cfg.fix_max  <= 4'd8;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LAT_MAX:  r_cfg.lat_max  <= i_cfg_data[33:0];
                CFG_LON_MAX:  r_cfg.lon_max  <= i_cfg_data[34:0];
                CFG_ALT_MIN:  r_cfg.alt_min  <= i_cfg_data[37:0];
                CFG_ALT_MAX:  r_cfg.alt_max  <= i_cfg_data[37:0];
                CFG_DOP_MAX:  r_cfg.dop_max  <= i_cfg_data[33:0];
                CFG_SPD_MAX:  r_cfg.spd_max  <= i_cfg_data[24:0];
                CFG_SATS_MAX: r_cfg.sats_max <= i_cfg_data[6:0];
                default:      r_cfg.fix_max  <= i_cfg_data[3:0];
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_xfer;
        end
        if (in_xfer) r_in_byte <= i_s_axis_tdata;
    end

    nsfp_core #(
        .FIELD_MAX_CHARS(FIELD_MAX_CHARS),
        .FRACTION_DIGITS(FRACTION_DIGITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_byte  (r_in_byte),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (res.cnt != 2'd0) begin
            r_mem[r_wr]  <= res.item0;
            r_last[r_wr] <= (res.cnt == 2'd1);
        end
        if (res.cnt == 2'd2) begin
            r_mem[r_wr + PW'(1)]  <= res.item1;
            r_last[r_wr + PW'(1)] <= 1'b1;
        end
    end

    // result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PW'(res.cnt);
            r_rd    <= r_rd + PW'(out_xfer);
            r_count <= r_count + (PW+1)'(res.cnt) - (PW+1)'(out_xfer);
        end
    end

    assign o_m_axis_tdata = r_mem[r_rd].value;
    assign o_m_axis_tuser = {r_mem[r_rd].kind, r_mem[r_rd].quantity};
    assign o_m_axis_tlast = r_last[r_rd];

endmodule
`default_nettype wire

// ===== rtl/nsfp_core.sv =====
// sentence state machine, field accumulators and limit checks, one byte per cycle
`timescale 1ns / 1ps
`default_nettype none
module nsfp_core import nsfp_pkg::*; #(
    parameter int FIELD_MAX_CHARS = FIELD_MAX_CHARS_DEF,
    parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    input  wire t_cfg       i_cfg,
    output t_res            o_res
);

    localparam int LW = $clog2(FIELD_MAX_CHARS + 1);
    localparam logic [VALUE_W-1:0] SC     = VALUE_W'(pow10(FRACTION_DIGITS));
    localparam logic [VALUE_W-1:0] IPMAX  = VALUE_W'(MAG_MAX / pow10(FRACTION_DIGITS));
    localparam logic [VALUE_W-1:0] IPSMAX = VALUE_W'((MAG_MAX / pow10(FRACTION_DIGITS))
                                                     * pow10(FRACTION_DIGITS));
    localparam logic [VALUE_W-1:0] FW0 = VALUE_W'(pow10(FRACTION_DIGITS - 1));
    localparam logic [VALUE_W-1:0] FW1 = VALUE_W'(pow10(FRACTION_DIGITS - 2));
    localparam logic [VALUE_W-1:0] FW2 = VALUE_W'(pow10(FRACTION_DIGITS - 3));
    localparam logic [VALUE_W-1:0] FW3 = VALUE_W'(pow10(FRACTION_DIGITS - 4));
    localparam logic [VALUE_W-1:0] FW4 = VALUE_W'(pow10(FRACTION_DIGITS - 5));
    localparam logic [VALUE_W-1:0] FW5 = VALUE_W'(pow10(FRACTION_DIGITS - 6));

    typedef enum logic [3:0] {
        PH_HUNT   = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_OPEN   = 4'b0100,
        PH_FIELDS = 4'b1000
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [2:0]         r_hpos, n_hpos;
    logic [5:0]         r_mask, n_mask;
    logic [2:0]         r_type, n_type;
    logic [4:0]         r_fidx, n_fidx;
    logic [LW-1:0]      r_flen, n_flen;
    logic [VALUE_W-1:0] r_acc, n_acc;     // padded magnitude, saturated
    logic [VALUE_W-1:0] r_ipa, n_ipa;     // integer part, saturated
    logic [VALUE_W-1:0] r_ips, n_ips;     // integer part times scale, saturated
    logic [23:0]        r_bcd, n_bcd;     // last six integer digits
    logic [2:0]         r_frac, n_frac;
    logic [7:0]         r_fchar, n_fchar;
    logic               r_neg, n_neg, r_dot, n_dot, r_stop, n_stop;
    logic [VALUE_W-1:0] r_lat, n_lat, r_lon, n_lon;

    // field finish values
    logic [3:0]         q_now;
    logic               negz;
    logic [VALUE_W:0]   sv;
    logic               fin_ok;
    logic [VALUE_W-1:0] fin_val;
    logic [6:0]         hh, mm, ss;

    // digit accumulation helpers
    logic [3:0]         dig;
    logic               is_dig;
    logic [VALUE_W+4:0] t_acc_i, t_acc_f, t_ipa, t_ips;
    logic [VALUE_W-1:0] fw_sel;

    logic               do_finish, do_commit, clr;

    assign q_now = (r_fidx < 5'd20) ? qty_map(r_type, r_fidx) : Q_NONE;
    assign dig = 4'(i_byte - CH_0);
    assign is_dig = (i_byte >= CH_0) && (i_byte <= CH_9);

    // fraction digit weight
    always_comb begin
        unique case (r_frac)
            3'd0:    fw_sel = FW0;
            3'd1:    fw_sel = FW1;
            3'd2:    fw_sel = FW2;
            3'd3:    fw_sel = FW3;
            3'd4:    fw_sel = FW4;
            default: fw_sel = FW5;
        endcase
    end

    // next-value candidates of the accumulators
    assign t_acc_i = {5'd0, r_acc} * (VALUE_W+5)'(10) + (VALUE_W+5)'(SC) * (VALUE_W+5)'(dig);
    assign t_acc_f = {5'd0, r_acc} + (VALUE_W+5)'(fw_sel) * (VALUE_W+5)'(dig);
    assign t_ipa   = {5'd0, r_ipa} * (VALUE_W+5)'(10) + (VALUE_W+5)'(dig);
    assign t_ips   = {5'd0, r_ips} * (VALUE_W+5)'(10) + (VALUE_W+5)'(SC) * (VALUE_W+5)'(dig);

    // limit checks on the field in progress
    assign negz = r_neg && (r_acc != '0);
    assign sv = negz ? -{1'b0, r_acc} : {1'b0, r_acc};
    assign hh = 7'(r_bcd[23:20]) * 7'd10 + 7'(r_bcd[19:16]);
    assign mm = 7'(r_bcd[15:12]) * 7'd10 + 7'(r_bcd[11:8]);
    assign ss = 7'(r_bcd[7:4]) * 7'd10 + 7'(r_bcd[3:0]);

    always_comb begin
        fin_ok = 1'b0;
        fin_val = sv[VALUE_W-1:0];
        unique case (q_now)
            Q_TIME: begin
                fin_ok = !negz && hh <= 7'd23 && mm <= 7'd59 && ss <= 7'd59;
                fin_val = r_ipa;
            end
            Q_DATE: begin
                fin_ok = !negz && hh >= 7'd1 && hh <= 7'd31 && mm >= 7'd1 && mm <= 7'd12;
                fin_val = r_ipa;
            end
            Q_LAT: begin
                fin_ok = !negz && r_acc <= VALUE_W'(i_cfg.lat_max);
            end
            Q_LON: begin
                fin_ok = !negz && r_acc <= VALUE_W'(i_cfg.lon_max);
            end
            Q_LATDIR: begin
                fin_ok = (r_fchar == CH_N) || (r_fchar == CH_S);
                fin_val = VALUE_W'(r_fchar);
            end
            Q_LONDIR: begin
                fin_ok = (r_fchar == CH_E) || (r_fchar == CH_W);
                fin_val = VALUE_W'(r_fchar);
            end
            Q_ALT: begin
                fin_ok = ($signed(sv) >= $signed((VALUE_W+1)'($signed(i_cfg.alt_min))))
                      && ($signed(sv) <= $signed((VALUE_W+1)'($signed(i_cfg.alt_max))));
            end
            Q_FIX: begin
                fin_ok = !negz && r_ipa <= VALUE_W'(i_cfg.fix_max);
                fin_val = r_ipa;
            end
            Q_SATS: begin
                fin_ok = !negz && r_ipa <= VALUE_W'(i_cfg.sats_max);
                fin_val = r_ipa;
            end
            Q_HDOP, Q_VDOP: begin
                fin_ok = !negz && r_acc <= VALUE_W'(i_cfg.dop_max);
            end
            Q_SPEED: begin
                fin_ok = !negz && r_acc <= VALUE_W'(i_cfg.spd_max);
                fin_val = r_ips;
            end
            Q_MODE1: begin
                fin_ok = 1'b1;
                fin_val = (r_fchar == CH_A) ? VALUE_W'(1) :
                          (r_fchar == CH_M) ? VALUE_W'(2) : '0;
            end
            Q_MODE2: begin
                fin_ok = !negz && r_ipa >= VALUE_W'(1) && r_ipa <= VALUE_W'(3);
                fin_val = r_ipa;
            end
            Q_MODEIND: begin
                fin_ok = 1'b1;
                fin_val = (r_fchar == CH_A) ? VALUE_W'(1) :
                          (r_fchar == CH_D) ? VALUE_W'(2) :
                          (r_fchar == CH_E) ? VALUE_W'(3) :
                          (r_fchar == CH_M) ? VALUE_W'(4) : '0;
            end
            default: fin_ok = 1'b0;
        endcase
    end

    // sentence state machine
    always_comb begin
        n_phase = r_phase;
        n_hpos  = r_hpos;
        n_mask  = r_mask;
        n_type  = r_type;
        n_fidx  = r_fidx;
        n_flen  = r_flen;
        n_acc   = r_acc;
        n_ipa   = r_ipa;
        n_ips   = r_ips;
        n_bcd   = r_bcd;
        n_frac  = r_frac;
        n_fchar = r_fchar;
        n_neg   = r_neg;
        n_dot   = r_dot;
        n_stop  = r_stop;
        n_lat   = r_lat;
        n_lon   = r_lon;
        do_finish = 1'b0;
        do_commit = 1'b0;
        clr = 1'b0;
        unique case (r_phase)
            PH_HEADER: begin
                if (i_byte == CH_DOLLAR) begin
                    n_hpos = '0;
                    n_mask = 6'h3F;
                end else begin
                    for (int t = 0; t < 6; t++) begin
                        if (r_hpos >= 3'd5 || hdr_char(3'(t), r_hpos) != i_byte)
                            n_mask[t] = 1'b0;
                    end
                    n_hpos = r_hpos + 3'd1;
                    if (n_mask == '0) begin
                        n_phase = PH_HUNT;
                    end else if (n_hpos >= 3'd5) begin
                        for (int t = 5; t >= 0; t--) begin
                            if (n_mask[t]) n_type = 3'(t);
                        end
                        n_phase = PH_OPEN;
                    end
                end
            end
            PH_OPEN: begin
                if (i_byte == CH_DOLLAR) begin
                    do_commit = 1'b1;
                    n_phase = PH_HEADER;
                    n_hpos = '0;
                    n_mask = 6'h3F;
                end else if (i_byte == CH_NL) begin
                    do_commit = 1'b1;
                    n_phase = PH_HUNT;
                end else begin
                    n_fidx = '0;
                    clr = 1'b1;
                    n_phase = PH_FIELDS;
                end
            end
            PH_FIELDS: begin
                if (i_byte == CH_DOLLAR) begin
                    do_commit = 1'b1;
                    n_phase = PH_HEADER;
                    n_hpos = '0;
                    n_mask = 6'h3F;
                end else if (i_byte == CH_NL) begin
                    do_commit = 1'b1;
                    n_phase = PH_HUNT;
                end else if (i_byte == CH_COMMA || i_byte == CH_STAR) begin
                    do_finish = (r_flen != '0) && fin_ok;
                    n_fidx = r_fidx + 5'd1;
                    if (n_fidx >= field_count(r_type)) begin
                        do_commit = 1'b1;
                        n_phase = PH_HUNT;
                    end
                    clr = 1'b1;
                end else if (r_flen >= LW'(FIELD_MAX_CHARS)) begin
                    do_commit = 1'b1;
                    n_phase = PH_HUNT;
                end else begin
                    // character of a field
                    n_flen = r_flen + LW'(1);
                    if (r_flen == '0) n_fchar = i_byte;
                    if (((q_now == Q_TIME) || (q_now == Q_DATE))
                        && r_flen >= LW'(TIMEDATE_CHARS)) begin
                        n_stop = r_stop;
                    end else if (!r_stop) begin
                        if (r_flen == '0 && (i_byte == CH_MINUS || i_byte == CH_PLUS)) begin
                            n_neg = (i_byte == CH_MINUS);
                        end else if (is_dig) begin
                            if (!r_dot) begin
                                n_acc = (t_acc_i > (VALUE_W+5)'(MAG_MAX)) ? MAG_MAX
                                        : t_acc_i[VALUE_W-1:0];
                                n_ipa = (t_ipa > (VALUE_W+5)'(IPMAX)) ? IPMAX
                                        : t_ipa[VALUE_W-1:0];
                                n_ips = (t_ips > (VALUE_W+5)'(IPSMAX)) ? IPSMAX
                                        : t_ips[VALUE_W-1:0];
                                n_bcd = {r_bcd[19:0], dig};
                            end else if (r_frac < 3'(FRACTION_DIGITS)) begin
                                n_acc = (t_acc_f > (VALUE_W+5)'(MAG_MAX)) ? MAG_MAX
                                        : t_acc_f[VALUE_W-1:0];
                                n_frac = r_frac + 3'd1;
                            end
                        end else if (i_byte == CH_DOT && !r_dot) begin
                            n_dot = 1'b1;
                        end else begin
                            n_stop = 1'b1;
                        end
                    end
                end
            end
            default: begin
                if (i_byte == CH_DOLLAR) begin
                    n_phase = PH_HEADER;
                    n_hpos = '0;
                    n_mask = 6'h3F;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
        endcase
        // stage position fields
        if (do_finish && q_now == Q_LAT) begin
            if (!negz && r_acc <= VALUE_W'(i_cfg.lat_max)) n_lat = sv[VALUE_W-1:0];
        end
        if (do_finish && q_now == Q_LON) begin
            if (!negz && r_acc <= VALUE_W'(i_cfg.lon_max)) n_lon = sv[VALUE_W-1:0];
        end
        if (clr) begin
            n_flen = '0;
            n_acc = '0;
            n_ipa = '0;
            n_ips = '0;
            n_bcd = '0;
            n_frac = '0;
            n_fchar = '0;
            n_neg = 1'b0;
            n_dot = 1'b0;
            n_stop = 1'b0;
        end
    end

    // results of this byte
    always_comb begin
        o_res.cnt = 2'd0;
        o_res.item0 = '{quantity: q_now, value: fin_val, kind: r_type};
        o_res.item1 = '{quantity: Q_LON, value: n_lon, kind: r_type};
        if (do_commit) begin
            o_res.cnt = 2'd2;
            o_res.item0 = '{quantity: Q_LAT, value: n_lat, kind: r_type};
        end else if (do_finish && q_now != Q_LAT && q_now != Q_LON) begin
            o_res.cnt = 2'd1;
        end
        if (!i_valid) o_res.cnt = 2'd0;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_hpos  <= '0;
            r_mask  <= '0;
            r_type  <= '0;
            r_fidx  <= '0;
            r_flen  <= '0;
            r_acc   <= '0;
            r_ipa   <= '0;
            r_ips   <= '0;
            r_bcd   <= '0;
            r_frac  <= '0;
            r_fchar <= '0;
            r_neg   <= 1'b0;
            r_dot   <= 1'b0;
            r_stop  <= 1'b0;
            r_lat   <= '0;
            r_lon   <= '0;
        end else if (i_valid) begin
            r_phase <= n_phase;
            r_hpos  <= n_hpos;
            r_mask  <= n_mask;
            r_type  <= n_type;
            r_fidx  <= n_fidx;
            r_flen  <= n_flen;
            r_acc   <= n_acc;
            r_ipa   <= n_ipa;
            r_ips   <= n_ips;
            r_bcd   <= n_bcd;
            r_frac  <= n_frac;
            r_fchar <= n_fchar;
            r_neg   <= n_neg;
            r_dot   <= n_dot;
            r_stop  <= n_stop;
            r_lat   <= n_lat;
            r_lon   <= n_lon;
        end
    end

endmodule
`default_nettype wire

// ===== tb/nmea_sentence_field_parser_top_tb.sv =====
// self-checking testbench of the nmea sentence field parser top level
`timescale 1ns / 1ps
module nmea_sentence_field_parser_top_tb;
    import nsfp_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 12;
    localparam int FLD_MAX = 16;
    localparam int FRAC_N = 5;
    localparam longint unsigned SCALE = 100000;
    localparam longint unsigned SAT_MAG = 64'd549755813887;

    typedef enum logic [1:0] {P_HUNT, P_HDR, P_OPEN, P_FLD} t_phase;

    typedef struct {
        logic [3:0]  qty;
        logic [39:0] val;
        logic [2:0]  kind;
        logic        last;
    } t_update;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_axis_tvalid = 1'b0;
    logic [7:0] i_s_axis_tdata = '0;
    logic i_m_axis_tready = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [2:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic o_s_axis_tready, o_m_axis_tvalid, o_m_axis_tlast, o_cfg_ready;
    logic [VALUE_W-1:0] o_m_axis_tdata;
    logic [6:0] o_m_axis_tuser;

    nmea_sentence_field_parser_top u_top (.*);

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // rx bytes waiting to be sent, updates waiting to be seen
    logic [7:0] rx_bytes_q [$];
    t_update    pending_updates [$];
    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int errors = 0;
    int bytes_sent = 0;
    int updates_seen = 0;
    int cycle_cnt = 0;

    // limit registers as the block should hold them
    logic [33:0] lat_lim = 34'd900000000;
    logic [34:0] lon_lim = 35'd1800000000;
    logic [37:0] alt_lo = 38'h3FFFFFFFFF - 38'd49999999;
    logic [37:0] alt_hi = 38'd1000000000;
    logic [33:0] dop_lim = 34'd9999000;
    logic [24:0] spd_lim = 25'd25500000;
    logic [6:0]  sats_lim = 7'd12;
    logic [3:0]  fix_lim = 4'd8;

    // parser state as the block should hold it
    t_phase ph = P_HUNT;
    logic [2:0] hpos = '0;
    logic [2:0] stype = '0;
    logic [5:0] cand = '0;
    logic [4:0] fidx = '0;
    logic [4:0] flen = '0;
    longint unsigned acc = 0;
    int fdig = 0;
    logic [7:0] fch = '0;
    bit negf = 0, dotf = 0, stopf = 0;
    longint stg_lat = 0, stg_lon = 0;

    string hdr_name [6] = '{"GPRMC", "GPVTG", "GPGGA", "GPGSA", "GPGSV", "GPGLL"};
    int    fld_total [6] = '{13, 10, 15, 18, 20, 8};

    function automatic logic [3:0] field_qty(logic [2:0] k, logic [4:0] f);
        case (k)
            K_RMC: case (f)
                0: return Q_TIME;   2: return Q_LAT;    3: return Q_LATDIR;
                4: return Q_LON;    5: return Q_LONDIR; 8: return Q_DATE;
                11: return Q_MODEIND;
                default: return Q_NONE;
            endcase
            K_VTG: case (f)
                6: return Q_SPEED;  8: return Q_MODEIND;
                default: return Q_NONE;
            endcase
            K_GGA: case (f)
                0: return Q_TIME;   1: return Q_LAT;    2: return Q_LATDIR;
                3: return Q_LON;    4: return Q_LONDIR; 5: return Q_FIX;
                6: return Q_SATS;   7: return Q_HDOP;   8: return Q_ALT;
                default: return Q_NONE;
            endcase
            K_GSA: case (f)
                0: return Q_MODE1;  1: return Q_MODE2;  15: return Q_HDOP;
                16: return Q_VDOP;
                default: return Q_NONE;
            endcase
            K_GLL: case (f)
                0: return Q_LAT;    1: return Q_LATDIR; 2: return Q_LON;
                3: return Q_LONDIR; 4: return Q_TIME;   6: return Q_MODEIND;
                default: return Q_NONE;
            endcase
            default: return Q_NONE;
        endcase
    endfunction

    function automatic longint unsigned times10_add(longint unsigned a, int d);
        if (a > (SAT_MAG - d) / 10) return SAT_MAG;
        return a * 10 + d;
    endfunction

    function automatic void push_update(logic [3:0] q, longint v);
        t_update u;
        u.qty = q;
        u.val = v[39:0];
        u.kind = stype;
        u.last = 1'b0;
        pending_updates.push_back(u);
    endfunction

    function automatic void push_position();
        push_update(Q_LAT, stg_lat);
        push_update(Q_LON, stg_lon);
    endfunction

    function automatic void clear_field();
        flen = '0;
        acc = 0;
        fdig = 0;
        fch = '0;
        negf = 0;
        dotf = 0;
        stopf = 0;
    endfunction

    function automatic void open_header();
        ph = P_HDR;
        hpos = '0;
        cand = 6'h3F;
    endfunction

    // one character into the current field
    function automatic void field_char(logic [7:0] c);
        logic [3:0] q;
        q = field_qty(stype, fidx);
        if (flen == 0) fch = c;
        if ((q == Q_TIME || q == Q_DATE) && flen >= TIMEDATE_CHARS) return;
        if (stopf) return;
        if (flen == 0 && (c == CH_MINUS || c == CH_PLUS)) begin
            negf = (c == CH_MINUS);
        end else if (c >= CH_0 && c <= CH_9) begin
            if (!dotf) begin
                acc = times10_add(acc, c - CH_0);
            end else if (fdig < FRAC_N) begin
                acc = times10_add(acc, c - CH_0);
                fdig++;
            end
        end else if (c == CH_DOT && !dotf) begin
            dotf = 1;
        end else begin
            stopf = 1;
        end
    endfunction

    // convert the finished field and check it against its limits
    function automatic void close_field();
        logic [3:0] q;
        longint unsigned mag, ip, dd, mm, ss;
        longint sv, lo, hi;
        bit negz;
        q = field_qty(stype, fidx);
        mag = acc;
        for (int i = fdig; i < FRAC_N; i++) mag = times10_add(mag, 0);
        negz = negf && mag != 0;
        sv = negz ? -longint'(mag) : longint'(mag);
        ip = mag / SCALE;
        dd = (ip / 10000) % 100;
        mm = (ip / 100) % 100;
        ss = ip % 100;
        lo = {{26{alt_lo[37]}}, alt_lo};
        hi = {{26{alt_hi[37]}}, alt_hi};
        case (q)
            Q_TIME:   if (!negz && dd <= 23 && mm <= 59 && ss <= 59) push_update(q, ip);
            Q_DATE:   if (!negz && dd >= 1 && dd <= 31 && mm >= 1 && mm <= 12)
                          push_update(q, ip);
            Q_LAT:    if (!negz && mag <= lat_lim) stg_lat = sv;
            Q_LON:    if (!negz && mag <= lon_lim) stg_lon = sv;
            Q_LATDIR: if (fch == CH_N || fch == CH_S) push_update(q, fch);
            Q_LONDIR: if (fch == CH_E || fch == CH_W) push_update(q, fch);
            Q_ALT:    if (sv >= lo && sv <= hi) push_update(q, sv);
            Q_FIX:    if (!negz && ip <= fix_lim) push_update(q, ip);
            Q_SATS:   if (!negz && ip <= sats_lim) push_update(q, ip);
            Q_HDOP, Q_VDOP: if (!negz && mag <= dop_lim) push_update(q, sv);
            Q_SPEED:  if (!negz && mag <= spd_lim) push_update(q, ip * SCALE);
            Q_MODE1:  push_update(q, fch == CH_A ? 1 : fch == CH_M ? 2 : 0);
            Q_MODE2:  if (!negz && ip >= 1 && ip <= 3) push_update(q, ip);
            Q_MODEIND: push_update(q, fch == CH_A ? 1 : fch == CH_D ? 2 :
                                      fch == CH_E ? 3 : fch == CH_M ? 4 : 0);
            default: ;
        endcase
    endfunction

    // predict the updates caused by one received byte
    function automatic void predict_byte(logic [7:0] c);
        int n0;
        n0 = pending_updates.size();
        case (ph)
            P_HDR: begin
                if (c == CH_DOLLAR) begin
                    open_header();
                end else begin
                    for (int t = 0; t < 6; t++)
                        if (hpos >= 5 || hdr_name[t][hpos] != c) cand[t] = 1'b0;
                    hpos++;
                    if (cand == 0) begin
                        ph = P_HUNT;
                    end else if (hpos >= 5) begin
                        for (int t = 5; t >= 0; t--) if (cand[t]) stype = t;
                        ph = P_OPEN;
                    end
                end
            end
            P_OPEN: begin
                if (c == CH_DOLLAR) begin
                    push_position();
                    open_header();
                end else if (c == CH_NL) begin
                    push_position();
                    ph = P_HUNT;
                end else begin
                    fidx = '0;
                    clear_field();
                    ph = P_FLD;
                end
            end
            P_FLD: begin
                if (c == CH_DOLLAR) begin
                    push_position();
                    open_header();
                end else if (c == CH_NL) begin
                    push_position();
                    ph = P_HUNT;
                end else if (c == CH_COMMA || c == CH_STAR) begin
                    if (flen > 0) close_field();
                    fidx++;
                    if (stype >= 6 || fidx >= fld_total[stype]) begin
                        push_position();
                        ph = P_HUNT;
                    end
                    clear_field();
                end else if (flen >= FLD_MAX) begin
                    push_position();
                    ph = P_HUNT;
                end else begin
                    field_char(c);
                    flen++;
                end
            end
            default: if (c == CH_DOLLAR) open_header();
        endcase
        if (pending_updates.size() > n0)
            pending_updates[pending_updates.size() - 1].last = 1'b1;
    endfunction

    // byte driver, predicts on every transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                predict_byte(i_s_axis_tdata);
                bytes_sent++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (rx_bytes_q.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    i_s_axis_tdata <= rx_bytes_q.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // update monitor and checker
    always @(posedge i_clk) begin
        t_update e;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                updates_seen++;
                if (pending_updates.size() == 0) begin
                    $error("unexpected update: quantity %0d value %0d",
                           o_m_axis_tuser[3:0], $signed(o_m_axis_tdata));
                    errors++;
                end else begin
                    e = pending_updates.pop_front();
                    if (o_m_axis_tuser[3:0] !== e.qty) begin
                        $error("quantity: expected %0d, got %0d", e.qty, o_m_axis_tuser[3:0]);
                        errors++;
                    end
                    if (o_m_axis_tdata !== e.val) begin
                        $error("value: expected %0d, got %0d", $signed(e.val),
                               $signed(o_m_axis_tdata));
                        errors++;
                    end
                    if (o_m_axis_tuser[6:4] !== e.kind) begin
                        $error("sentence_kind: expected %0d, got %0d", e.kind,
                               o_m_axis_tuser[6:4]);
                        errors++;
                    end
                    if (o_m_axis_tlast !== e.last) begin
                        $error("last_item: expected %0b, got %0b", e.last, o_m_axis_tlast);
                        errors++;
                    end
                end
            end
            i_m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("timeout with %0d updates outstanding", pending_updates.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // register write over the config channel, only while the parser is idle
    task automatic write_reg(logic [2:0] idx, longint v);
        i_cfg_index <= idx;
        i_cfg_data <= v[CFG_W-1:0];
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_LAT_MAX:  lat_lim = v[33:0];
            CFG_LON_MAX:  lon_lim = v[34:0];
            CFG_ALT_MIN:  alt_lo = v[37:0];
            CFG_ALT_MAX:  alt_hi = v[37:0];
            CFG_DOP_MAX:  dop_lim = v[33:0];
            CFG_SPD_MAX:  spd_lim = v[24:0];
            CFG_SATS_MAX: sats_lim = v[6:0];
            default:      fix_lim = v[3:0];
        endcase
    endtask

    function automatic longint unsigned rand_upto(longint unsigned hi);
        longint unsigned r;
        r = {$urandom, $urandom};
        return r % (hi + 1);
    endfunction

    // all eight limits: extremes high, extremes low, or random
    task automatic load_limits(int sel);
        longint a, b;
        case (sel)
            0: begin
                write_reg(CFG_LAT_MAX, 9000000000);
                write_reg(CFG_LON_MAX, 18000000000);
                write_reg(CFG_ALT_MIN, -100000000000);
                write_reg(CFG_ALT_MAX, 100000000000);
                write_reg(CFG_DOP_MAX, 10000000000);
                write_reg(CFG_SPD_MAX, 25500000);
                write_reg(CFG_SATS_MAX, 99);
                write_reg(CFG_FIX_MAX, 9);
            end
            1: begin
                write_reg(CFG_LAT_MAX, 0);
                write_reg(CFG_LON_MAX, 0);
                write_reg(CFG_ALT_MIN, 0);
                write_reg(CFG_ALT_MAX, 0);
                write_reg(CFG_DOP_MAX, 0);
                write_reg(CFG_SPD_MAX, 0);
                write_reg(CFG_SATS_MAX, 0);
                write_reg(CFG_FIX_MAX, 0);
            end
            default: begin
                write_reg(CFG_LAT_MAX, rand_upto(9000000000));
                write_reg(CFG_LON_MAX, rand_upto(18000000000));
                a = longint'(rand_upto(400000000)) - 200000000;
                b = a + longint'(rand_upto(3000000000));
                write_reg(CFG_ALT_MIN, a);
                write_reg(CFG_ALT_MAX, b);
                write_reg(CFG_DOP_MAX, rand_upto(10000000000));
                write_reg(CFG_SPD_MAX, rand_upto(25500000));
                write_reg(CFG_SATS_MAX, $urandom_range(0, 99));
                write_reg(CFG_FIX_MAX, $urandom_range(0, 9));
            end
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic queue_text(string s);
        for (int i = 0; i < s.len(); i++) rx_bytes_q.push_back(s[i]);
    endtask

    function automatic string digits(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
        return s;
    endfunction

    // random field text, shaped by the quantity it lands in
    function automatic string make_field(logic [3:0] q);
        string s, letters;
        int r, ni, li;
        letters = "NSEWADMX";
        r = $urandom_range(0, 11);
        if (r == 0) return "";
        if (r == 1 || q == Q_LATDIR || q == Q_LONDIR || q == Q_MODE1 || q == Q_MODEIND) begin
            s = "";
            li = $urandom_range(0, 7);
            s = {s, letters.substr(li, li)};
            if (r == 1) begin
                li = $urandom_range(0, 7);
                s = {s, letters.substr(li, li)};
            end
            return s;
        end
        if ((q == Q_TIME || q == Q_DATE) && r < 8) begin
            if (q == Q_TIME)
                s = $sformatf("%02d%02d%02d.%02d", $urandom_range(0, 25),
                              $urandom_range(0, 61), $urandom_range(0, 61),
                              $urandom_range(0, 99));
            else
                s = $sformatf("%02d%02d%02d", $urandom_range(0, 32),
                              $urandom_range(0, 13), $urandom_range(0, 99));
            return s;
        end
        s = "";
        case ($urandom_range(0, 7))
            0: s = "-";
            1: s = "+";
            default: ;
        endcase
        if (q == Q_FIX || q == Q_SATS || q == Q_MODE2) ni = $urandom_range(0, 2);
        else if ($urandom_range(0, 5) == 0) ni = $urandom_range(0, 13);
        else ni = $urandom_range(0, 5);
        s = {s, digits(ni)};
        if ($urandom_range(0, 2) != 0) s = {s, ".", digits($urandom_range(0, 7))};
        if ($urandom_range(0, 9) == 0) s = {s, $sformatf("%c", $urandom_range(0, 255))};
        if (s.len() > 14) s = s.substr(0, 14);
        return s;
    endfunction

    // one sentence, mostly well formed, sometimes broken
    task automatic queue_sentence();
        string s, hdr;
        int k, nf, tail;
        k = $urandom_range(0, 5);
        hdr = hdr_name[k];
        if ($urandom_range(0, 19) == 0) hdr[$urandom_range(0, 4)] = "Q";
        s = {"$", hdr};
        s = {s, ($urandom_range(0, 19) == 0) ? $sformatf("%c", $urandom_range(0, 255)) : ","};
        nf = ($urandom_range(0, 3) == 0) ? $urandom_range(0, fld_total[k]) : fld_total[k];
        tail = $urandom_range(0, 3);
        for (int i = 0; i < nf; i++) begin
            if ($urandom_range(0, 39) == 0) s = {s, digits($urandom_range(17, 20))};
            else s = {s, make_field(field_qty(k, i))};
            if (i < nf - 1 || tail == 0) s = {s, ","};
            else if (tail == 1) s = {s, "*"};
        end
        if (tail == 2) s = {s, "*5A\n"};
        else if (tail == 3) s = {s, "\n"};
        queue_text(s);
        for (int i = $urandom_range(0, 2); i > 0; i--)
            rx_bytes_q.push_back($urandom_range(0, 255));
    endtask

    task automatic settle();
        while (rx_bytes_q.size() > 0 || i_s_axis_tvalid || pending_updates.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // stimulus sequence
    initial begin
        int target;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: limits at reset, limit edges, modes, header restarts, long field
        queue_text("$GPGGA,235959,9000.00000,N,18000.00000,W,8,12,99.99,-500.00000,M\n");
        queue_text("$GPGSA,A,3,,,,,,,,,,,,,1.5,-0.5,\n$GPGSA,M,4*\n$GPGSA,x,0\n");
        queue_text("$GPRMC,240000,A,9000.00001,S,1.2.3,E,,,311299,,,D*00\n");
        queue_text("$GPVTG,,,,,,,255.99,,E\n$GP$GPGLL,,N,,W,000000,,M,\n");
        queue_text("$GPXYZ,1\n$GPGSV,1,2,3$GPGLL,12345678901234567,N\n$GPRMC$GPVTG\n");
        settle();

        for (int p = 0; p < 8; p++) begin
            load_limits(p);
            src_idle_pct = (p % 4 == 1 || p % 4 == 3) ? ((p % 4 == 3) ? 10 : 52) : 0;
            snk_stall_pct = (p % 4 == 2) ? 52 : ((p % 4 == 3) ? 10 : 0);
            target = rx_bytes_q.size() + 120;
            while (rx_bytes_q.size() < target) begin
                if ($urandom_range(0, 9) == 0) rx_bytes_q.push_back($urandom_range(0, 255));
                else queue_sentence();
            end
            settle();
        end

        $display("%0d bytes sent, %0d updates checked across 9 limit settings", bytes_sent,
                 updates_seen);
        $display("idle patterns: none, sender gaps, receiver stalls, both");
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/nsfp_pkg.sv
rtl/nsfp_core.sv
rtl/nmea_sentence_field_parser_top.sv
tb/nmea_sentence_field_parser_top_tb.sv
